[hw/rtl/bcs_pkg.sv]
`default_nettype none
package bcs_pkg;

  typedef struct packed {
    logic               op;
    logic signed [31:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               result_last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT_I,
    S_SORT_KEY,
    S_SORT_CMP,
    S_SORT_PUT,
    S_SCAN,
    S_DEC,
    S_EMIT
  } state_t;

  localparam logic CFG_BLOCK_LEN = 1'b0;
  localparam logic CFG_KEEP_LOW  = 1'b1;

  localparam logic OP_LOCAL = 1'b0;

endpackage
`default_nettype wire

[hw/rtl/bcs_ram.sv]
`default_nettype none
module bcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/block_compare_split.sv]
`default_nettype none
// Compare-split step of an odd-even transposition sort. Words load the local
// and neighbour blocks at one per cycle while idle; the word marked last starts
// the work and raises busy. The local block is then insertion-sorted in its
// memory (one compare per cycle while an entry shifts down), after which each
// exchange round scans both memories side by side and swaps one pair, repeated
// until no pair qualifies. Finally the n local words are emitted, one per
// cycle, each on result for a single cycle marked by result_valid; the
// receiver cannot hold them off. Configuration writes are always taken.
module block_compare_split #(
  parameter int BLOCK_MAX = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire bcs_pkg::in_t  item,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_index,
  input  wire logic [6:0]    cfg_data,
  output bcs_pkg::out_t      result,
  output logic               result_valid
);
  import bcs_pkg::*;

  localparam int AW = $clog2(BLOCK_MAX);
  localparam int CW = $clog2(BLOCK_MAX + 1);

  state_t state, state_next;

  logic [6:0]    block_len;
  logic          keep_low;
  logic [CW-1:0] n;
  logic [CW-1:0] local_count, neighbour_count;
  logic [CW-1:0] i, j, k, pidx;
  logic          pend;
  logic [31:0]   key;
  logic [31:0]   lbest, nbest;
  logic [AW-1:0] li, ni;

  logic          l_we, n_we;
  logic [AW-1:0] l_waddr, n_waddr, l_raddr, n_raddr;
  logic [31:0]   l_wdata, n_wdata, l_rdata, n_rdata;

  logic accept, do_swap, scan_issue, scan_end;
  logic l_better, n_better;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;

  always_comb begin
    if (block_len == 7'd0) begin
      n = CW'(1);
    end else if (32'(block_len) > BLOCK_MAX) begin
      n = CW'(BLOCK_MAX);
    end else begin
      n = CW'(block_len);
    end
  end

  // In keep-low mode the local side hunts its maximum and the neighbour its
  // minimum; the roles flip otherwise. Strict compares keep the lowest index.
  assign l_better = keep_low ? ($signed(lbest) < $signed(l_rdata))
                             : ($signed(l_rdata) < $signed(lbest));
  assign n_better = keep_low ? ($signed(n_rdata) < $signed(nbest))
                             : ($signed(nbest) < $signed(n_rdata));
  assign do_swap  = keep_low ? ($signed(nbest) < $signed(lbest))
                             : ($signed(lbest) < $signed(nbest));
  assign scan_issue = (k < n);
  assign scan_end   = !scan_issue && pend;

  bcs_ram #(.WIDTH(32), .DEPTH(BLOCK_MAX)) u_local (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  bcs_ram #(.WIDTH(32), .DEPTH(BLOCK_MAX)) u_neigh (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  always_comb begin
    state_next = state;
    l_we    = 1'b0;
    n_we    = 1'b0;
    l_waddr = local_count[AW-1:0];
    n_waddr = neighbour_count[AW-1:0];
    l_wdata = item.value;
    n_wdata = item.value;
    l_raddr = k[AW-1:0];
    n_raddr = k[AW-1:0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.op == OP_LOCAL) begin
            l_we = (local_count < n);
          end else begin
            n_we = (neighbour_count < n);
          end
          if (item.last) begin
            state_next = S_SORT_I;
          end
        end
      end
      S_SORT_I: begin
        l_raddr = i[AW-1:0];
        state_next = (i < n) ? S_SORT_KEY : S_SCAN;
      end
      S_SORT_KEY: begin
        l_raddr = AW'(j - CW'(1));
        state_next = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        l_we    = 1'b1;
        l_waddr = j[AW-1:0];
        if ($signed(key) < $signed(l_rdata)) begin
          l_wdata = l_rdata;
          l_raddr = AW'(j - CW'(2));
          if (j == CW'(1)) begin
            state_next = S_SORT_PUT;
          end
        end else begin
          l_wdata    = key;
          state_next = S_SORT_I;
        end
      end
      S_SORT_PUT: begin
        l_we       = 1'b1;
        l_waddr    = '0;
        l_wdata    = key;
        state_next = S_SORT_I;
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (do_swap) begin
          l_we       = 1'b1;
          l_waddr    = li;
          l_wdata    = nbest;
          n_we       = 1'b1;
          n_waddr    = ni;
          n_wdata    = lbest;
          state_next = S_SCAN;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (scan_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      block_len       <= 7'd64;
      keep_low        <= 1'b1;
      local_count     <= '0;
      neighbour_count <= '0;
      result_valid    <= 1'b0;
      pend            <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BLOCK_LEN) begin
          block_len <= cfg_data;
        end else if (cfg_index == CFG_KEEP_LOW) begin
          keep_low <= cfg_data[0];
        end
      end
      if (l_we && state == S_IDLE) begin
        local_count <= local_count + CW'(1);
      end
      if (n_we && state == S_IDLE) begin
        neighbour_count <= neighbour_count + CW'(1);
      end
      if (state == S_SCAN || state == S_EMIT) begin
        pend <= scan_issue;
      end else begin
        pend <= 1'b0;
      end
      if (state == S_EMIT && pend) begin
        result_valid <= 1'b1;
      end
      if (state == S_EMIT && scan_end) begin
        local_count     <= '0;
        neighbour_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        i <= CW'(1);
        k <= '0;
      end
      S_SORT_I: begin
        j <= i;
        k <= '0;
      end
      S_SORT_KEY: begin
        key <= l_rdata;
      end
      S_SORT_CMP: begin
        if ($signed(key) < $signed(l_rdata) && j != CW'(1)) begin
          j <= j - CW'(1);
        end else if (!($signed(key) < $signed(l_rdata))) begin
          i <= i + CW'(1);
        end
      end
      S_SORT_PUT: begin
        i <= i + CW'(1);
      end
      S_SCAN: begin
        if (scan_issue) begin
          k <= k + CW'(1);
        end
        pidx <= k;
        if (pend) begin
          if (pidx == '0 || l_better) begin
            lbest <= l_rdata;
            li    <= pidx[AW-1:0];
          end
          if (pidx == '0 || n_better) begin
            nbest <= n_rdata;
            ni    <= pidx[AW-1:0];
          end
        end
      end
      S_DEC: begin
        k <= '0;
      end
      S_EMIT: begin
        if (scan_issue) begin
          k <= k + CW'(1);
        end
        pidx <= k;
        result.result_value <= l_rdata;
        result.result_last  <= (pidx == n - CW'(1));
      end
      default: begin
        k <= '0;
      end
    endcase
  end

endmodule
`default_nettype wire
